[rtl/h2df_pkg.sv]
package h2df_pkg;

    // Frame header layout and frame type limits
    localparam logic [3:0]  HDR_LEN_LAST   = 4'd2;
    localparam logic [3:0]  HDR_TYPE_IDX   = 4'd3;
    localparam logic [3:0]  HDR_FLAGS_IDX  = 4'd4;
    localparam logic [3:0]  HDR_LAST_IDX   = 4'd8;
    localparam logic [7:0]  TYPE_DATA      = 8'h00;
    localparam logic [7:0]  TYPE_KNOWN_MAX = 8'd10;

    // Receive window value after reset
    localparam logic [30:0] RX_WINDOW_RESET = 31'd20971520;

    // Result kinds
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // Framing event for one accepted byte
    typedef struct packed {
        logic        emit;
        logic        hdr_done;
        logic        data_frame;
        logic        kind;
        logic        last;
        logic [7:0]  pbyte;
        logic [3:0]  frame_type;
        logic [7:0]  frame_flags;
        logic        reserved_bit;
        logic [30:0] stream_id;
        logic [23:0] length;
    } t_parse_ev;

    // Flow-control view after this byte's accounting
    typedef struct packed {
        logic [30:0] window_left;
        logic        window_low;
        logic [23:0] update_needed;
    } t_win_info;

endpackage

[rtl/h2df_parse.sv]
module h2df_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_acc,
    input  logic [7:0]           i_byte,
    output h2df_pkg::t_parse_ev  o_ev
);
    import h2df_pkg::*;

    logic [3:0]  r_hdr_cnt,   n_hdr_cnt;
    logic [23:0] r_len,       n_len;
    logic [7:0]  r_type,      n_type;
    logic [7:0]  r_flags,     n_flags;
    logic [31:0] r_stream,    n_stream;
    logic [23:0] r_left,      n_left;

    // Header collection and payload byte count
    always_comb begin
        n_hdr_cnt = r_hdr_cnt;
        n_len     = r_len;
        n_type    = r_type;
        n_flags   = r_flags;
        n_stream  = r_stream;
        n_left    = r_left;
        o_ev      = '0;

        if (r_left != 24'd0) begin
            n_left     = r_left - 24'd1;
            o_ev.emit  = i_acc && (r_type <= TYPE_KNOWN_MAX);
            o_ev.kind  = KIND_PAYLOAD;
            o_ev.last  = (r_left == 24'd1);
            o_ev.pbyte = i_byte;
        end else begin
            if (r_hdr_cnt <= HDR_LEN_LAST) begin
                n_len = {r_len[15:0], i_byte};
            end else if (r_hdr_cnt == HDR_TYPE_IDX) begin
                n_type = i_byte;
            end else if (r_hdr_cnt == HDR_FLAGS_IDX) begin
                n_flags = i_byte;
            end else begin
                n_stream = {r_stream[23:0], i_byte};
            end

            if (r_hdr_cnt == HDR_LAST_IDX) begin
                n_hdr_cnt       = 4'd0;
                n_left          = n_len;
                o_ev.hdr_done   = i_acc;
                o_ev.data_frame = (n_type == TYPE_DATA);
                o_ev.emit       = i_acc && (n_type <= TYPE_KNOWN_MAX);
                o_ev.kind       = KIND_HEADER;
                o_ev.last       = (n_len == 24'd0);
            end else begin
                n_hdr_cnt = r_hdr_cnt + 4'd1;
            end
        end

        o_ev.frame_type   = n_type[3:0];
        o_ev.frame_flags  = n_flags;
        o_ev.reserved_bit = n_stream[31];
        o_ev.stream_id    = n_stream[30:0];
        o_ev.length       = n_len;
    end

    // Framing state, advanced on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt <= '0;
            r_len     <= '0;
            r_type    <= '0;
            r_flags   <= '0;
            r_stream  <= '0;
            r_left    <= '0;
        end else if (i_acc) begin
            r_hdr_cnt <= n_hdr_cnt;
            r_len     <= n_len;
            r_type    <= n_type;
            r_flags   <= n_flags;
            r_stream  <= n_stream;
            r_left    <= n_left;
        end
    end

endmodule

[rtl/h2df_window.sv]
module h2df_window (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [30:0]          i_cfg_wr_data,
    input  logic                 i_hdr_done,
    input  logic                 i_data_frame,
    input  logic [23:0]          i_length,
    output h2df_pkg::t_win_info  o_win
);
    import h2df_pkg::*;

    logic [30:0] r_window,  n_window;
    logic        r_low,     n_low;
    logic [23:0] r_pending, n_pending;
    logic [30:0] len_ext;

    assign len_ext = {7'd0, i_length};

    // Window accounting; a register write reloads the window
    always_comb begin
        n_window  = r_window;
        n_low     = r_low;
        n_pending = r_pending;
        if (i_cfg_wr_en) begin
            n_window = i_cfg_wr_data;
        end else if (i_hdr_done) begin
            n_low = 1'b0;
            if (i_data_frame) begin
                if (r_window <= len_ext) begin
                    n_low     = 1'b1;
                    n_pending = i_length;
                    n_window  = '0;
                end else begin
                    n_window = r_window - len_ext;
                end
            end
        end
    end

    assign o_win.window_left   = n_window;
    assign o_win.window_low    = n_low;
    assign o_win.update_needed = n_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= RX_WINDOW_RESET;
            r_low     <= 1'b0;
            r_pending <= '0;
        end else begin
            r_window  <= n_window;
            r_low     <= n_low;
            r_pending <= n_pending;
        end
    end

endmodule

[rtl/http2_frame_deframer_top.sv]
// HTTP/2 receive deframer. Takes one byte per cycle, collects each 9-byte frame
// header and passes on the payload. Frames of type 0 to 10 give one header
// result when the ninth header byte arrives, then one result per payload byte,
// with o_last on the final result of the frame; frames of other types are
// counted off and dropped. Each DATA frame lowers the receive window by its
// length, saturating at zero and raising o_window_low. A write on the
// configuration port reloads the window. Every byte is handled in the cycle it
// is accepted and its result appears in the output register on the next cycle,
// so the block sustains one byte per clock; it stalls input only while a
// result sits in the output register and the output side is stalled.
module http2_frame_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [30:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [3:0]  o_frame_type,
    output logic [7:0]  o_frame_flags,
    output logic        o_reserved_bit,
    output logic [30:0] o_stream_id,
    output logic [23:0] o_payload_length,
    output logic [7:0]  o_payload_byte,
    output logic        o_last,
    output logic [30:0] o_window_left,
    output logic        o_window_low,
    output logic [23:0] o_update_needed
);
    import h2df_pkg::*;

    logic      acc;
    t_parse_ev ev;
    t_win_info win;

    logic      r_out_valid, n_out_valid;
    t_parse_ev r_ev;
    t_win_info r_win;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign acc        = i_in_valid && !o_in_stall;

    h2df_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_byte  (i_in_byte),
        .o_ev    (ev)
    );

    h2df_window u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_hdr_done    (ev.hdr_done),
        .i_data_frame  (ev.data_frame),
        .i_length      (ev.length),
        .o_win         (win)
    );

    // Output register valid
    always_comb begin
        if (acc && ev.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload, loaded with each emitted transaction
    always_ff @(posedge i_clk) begin
        if (acc && ev.emit) begin
            r_ev  <= ev;
            r_win <= win;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_ev.kind;
    assign o_frame_type     = r_ev.frame_type;
    assign o_frame_flags    = r_ev.frame_flags;
    assign o_reserved_bit   = r_ev.reserved_bit;
    assign o_stream_id      = r_ev.stream_id;
    assign o_payload_length = r_ev.length;
    assign o_payload_byte   = r_ev.pbyte;
    assign o_last           = r_ev.last;
    assign o_window_left    = r_win.window_left;
    assign o_window_low     = r_win.window_low;
    assign o_update_needed  = r_win.update_needed;

endmodule

[bench/tb_http2_frame_deframer_top.sv]
`timescale 1ns / 100ps

module tb_http2_frame_deframer_top;
    import h2df_pkg::*;

    localparam int CYCLE_LIMIT  = 120000;
    localparam int DRAIN_CYCLES = 6;
    localparam int MAX_REPORTS  = 10;
    localparam int IDLE_PCT     = 20;

    // One deframed result as it leaves the block
    typedef struct packed {
        logic        kind;
        logic [3:0]  ftype;
        logic [7:0]  flags;
        logic        rsv;
        logic [30:0] sid;
        logic [23:0] len;
        logic [7:0]  pbyte;
        logic        lst;
        logic [30:0] wleft;
        logic        wlow;
        logic [23:0] upd;
    } t_frame_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [30:0] i_cfg_wr_data = '0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_in_byte = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_kind;
    logic [3:0]  o_frame_type;
    logic [7:0]  o_frame_flags;
    logic        o_reserved_bit;
    logic [30:0] o_stream_id;
    logic [23:0] o_payload_length;
    logic [7:0]  o_payload_byte;
    logic        o_last;
    logic [30:0] o_window_left;
    logic        o_window_low;
    logic [23:0] o_update_needed;

    // Deframer state mirrored by the predictor
    logic [3:0]  rx_hdr_cnt = '0;
    logic [23:0] rx_len = '0;
    logic [7:0]  rx_type = '0;
    logic [7:0]  rx_flags = '0;
    logic [31:0] rx_sid = '0;
    logic [23:0] rx_left = '0;
    logic [30:0] rx_win = RX_WINDOW_RESET;
    logic [23:0] rx_upd = '0;
    logic        rx_low = 1'b0;

    t_frame_result deframed_q[$];
    int          fail_cnt = 0;
    int          bytes_sent = 0;
    int          cycle_cnt = 0;
    logic        calm = 1'b0;

    http2_frame_deframer_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_byte        (i_in_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kind           (o_kind),
        .o_frame_type     (o_frame_type),
        .o_frame_flags    (o_frame_flags),
        .o_reserved_bit   (o_reserved_bit),
        .o_stream_id      (o_stream_id),
        .o_payload_length (o_payload_length),
        .o_payload_byte   (o_payload_byte),
        .o_last           (o_last),
        .o_window_left    (o_window_left),
        .o_window_low     (o_window_low),
        .o_update_needed  (o_update_needed)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Random back-pressure on the result side
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Build a result from the current frame state
    function automatic t_frame_result make_result(logic kind, logic [7:0] pb, logic lst);
        t_frame_result r;
        r.kind  = kind;
        r.ftype = rx_type[3:0];
        r.flags = rx_flags;
        r.rsv   = rx_sid[31];
        r.sid   = rx_sid[30:0];
        r.len   = rx_len;
        r.pbyte = pb;
        r.lst   = lst;
        r.wleft = rx_win;
        r.wlow  = rx_low;
        r.upd   = rx_upd;
        return r;
    endfunction

    // Append one predicted result to the queue
    task automatic queue_result(input t_frame_result r);
        deframed_q = {deframed_q, r};
    endtask

    // Predict the results of one accepted byte
    task automatic deframe_byte(input logic [7:0] b);
        if (rx_left != 0) begin
            rx_left = rx_left - 24'd1;
            if (rx_type <= TYPE_KNOWN_MAX)
                queue_result(make_result(KIND_PAYLOAD, b, rx_left == 0));
        end else begin
            if (rx_hdr_cnt <= HDR_LEN_LAST)
                rx_len = {rx_len[15:0], b};
            else if (rx_hdr_cnt == HDR_TYPE_IDX)
                rx_type = b;
            else if (rx_hdr_cnt == HDR_FLAGS_IDX)
                rx_flags = b;
            else
                rx_sid = {rx_sid[23:0], b};

            if (rx_hdr_cnt < HDR_LAST_IDX) begin
                rx_hdr_cnt = rx_hdr_cnt + 4'd1;
            end else begin
                rx_hdr_cnt = '0;
                rx_left = rx_len;
                rx_low = 1'b0;
                // DATA frames consume receive window, saturating at zero
                if (rx_type == TYPE_DATA) begin
                    if (rx_win <= {7'd0, rx_len}) begin
                        rx_low = 1'b1;
                        rx_upd = rx_len;
                        rx_win = '0;
                    end else begin
                        rx_win = rx_win - {7'd0, rx_len};
                    end
                end
                if (rx_type <= TYPE_KNOWN_MAX)
                    queue_result(make_result(KIND_HEADER, 8'h00, rx_len == 0));
            end
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_frame_result got;
        t_frame_result want;
        logic          bad;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_kind, o_frame_type, o_frame_flags, o_reserved_bit, o_stream_id,
                    o_payload_length, o_payload_byte, o_last, o_window_left,
                    o_window_low, o_update_needed};
            if (deframed_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= MAX_REPORTS)
                    $display("unexpected result at cycle %0d: kind=%0d type=%0d",
                             cycle_cnt, got.kind, got.ftype);
            end else begin
                want = deframed_q.pop_front();
                bad = (got.kind !== want.kind) || (got.ftype !== want.ftype) ||
                      (got.flags !== want.flags) || (got.rsv !== want.rsv) ||
                      (got.sid !== want.sid) || (got.len !== want.len) ||
                      (got.pbyte !== want.pbyte) || (got.lst !== want.lst) ||
                      (got.wleft !== want.wleft) || (got.wlow !== want.wlow) ||
                      (got.upd !== want.upd);
                if (bad) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS) begin
                        $display("mismatch at cycle %0d", cycle_cnt);
                        $display("  exp kind=%0d type=%0d flags=%h rsv=%0d sid=%h len=%h",
                                 want.kind, want.ftype, want.flags, want.rsv, want.sid,
                                 want.len);
                        $display("      byte=%h last=%0d win=%h low=%0d upd=%h",
                                 want.pbyte, want.lst, want.wleft, want.wlow, want.upd);
                        $display("  got kind=%0d type=%0d flags=%h rsv=%0d sid=%h len=%h",
                                 got.kind, got.ftype, got.flags, got.rsv, got.sid, got.len);
                        $display("      byte=%h last=%0d win=%h low=%0d upd=%h",
                                 got.pbyte, got.lst, got.wleft, got.wlow, got.upd);
                    end
                end
            end
        end
    end

    // Send one byte, with an occasional idle gap before it
    task automatic push_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        deframe_byte(b);
        bytes_sent++;
    endtask

    // Send header bytes first..final of a 9-byte frame header
    task automatic send_header_part(input logic [7:0] ftype, input logic [7:0] flags,
                                    input logic [31:0] sid, input logic [23:0] len,
                                    input int first, input int final_idx);
        logic [7:0] hdr [9];
        hdr = '{len[23:16], len[15:8], len[7:0], ftype, flags,
                sid[31:24], sid[23:16], sid[15:8], sid[7:0]};
        for (int i = first; i <= final_idx; i++)
            push_byte(hdr[i]);
    endtask

    task automatic send_header(input logic [7:0] ftype, input logic [7:0] flags,
                               input logic [31:0] sid, input logic [23:0] len);
        send_header_part(ftype, flags, sid, len, 0, 8);
    endtask

    task automatic send_payload(input int n);
        for (int i = 0; i < n; i++)
            push_byte(8'($urandom_range(0, 255)));
    endtask

    // Drop valid and wait for every expected result, then let the pipe settle
    task automatic settle();
        i_in_valid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write the receive window register; block must be idle
    task automatic write_window(input logic [30:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        rx_win = value;
        i_cfg_wr_en <= 1'b0;
    endtask

    // Window from reset, payload extremes, empty payload with reserved bit set
    task automatic test_reset_window();
        send_header(TYPE_DATA, 8'h01, 32'h0000_0001, 24'd3);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'hA5);
        send_header(TYPE_DATA + 8'd1, 8'hFF, 32'hFFFF_FFFF, 24'd0);
        settle();
    endtask

    // Every known type, plus unknown types that must be dropped silently
    task automatic test_frame_types();
        write_window(31'h7FFF_FFFF);
        for (int t = 0; t <= int'(TYPE_KNOWN_MAX); t++) begin
            send_header(8'(t), 8'(t * 23), {t[0], 31'(t * 32'h0abc_def1)}, 24'(t % 3));
            send_payload(t % 3);
        end
        send_header(TYPE_KNOWN_MAX + 8'd1, 8'h5A, 32'h0000_0003, 24'd2);
        send_payload(2);
        send_header(8'hFF, 8'h00, 32'h7FFF_FFFF, 24'd1);
        send_payload(1);
        send_header(TYPE_DATA + 8'd3, 8'h00, 32'h0000_0000, 24'd0);
        settle();
    endtask

    // Saturation, exact fit, zero window and reloads in the middle of a frame
    task automatic test_window_edges();
        write_window(31'd5);
        send_header(TYPE_DATA, 8'h00, 32'h0000_0005, 24'd5);
        send_payload(5);
        send_header(TYPE_DATA, 8'h00, 32'h0000_0005, 24'd0);
        settle();
        write_window(31'd0);
        send_header(TYPE_DATA, 8'h01, 32'h0000_0007, 24'd1);
        send_payload(1);
        settle();
        write_window(31'd7);
        send_header(TYPE_DATA, 8'h00, 32'h0000_0009, 24'd6);
        send_payload(6);
        // reload part way through a header, then part way through its payload
        send_header_part(TYPE_DATA, 8'h08, 32'h8000_0011, 24'd4, 0, 4);
        settle();
        write_window(31'd1000);
        send_header_part(TYPE_DATA, 8'h08, 32'h8000_0011, 24'd4, 5, 8);
        send_payload(2);
        settle();
        write_window(31'd0);
        send_payload(2);
        settle();
    endtask

    // Random well-formed frames over several window settings
    task automatic test_random_traffic();
        logic [30:0] win;
        logic [7:0]  ftype;
        logic [23:0] len;
        int          r;
        int          target;
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: win = 31'($urandom_range(0, 400));
                1: win = 31'h7FFF_FFFF;
                2: win = 31'd0;
                3: win = RX_WINDOW_RESET;
                4: win = 31'($urandom());
                default: win = 31'($urandom_range(1, 2000));
            endcase
            write_window(win);
            calm = (p == 3);
            target = bytes_sent + 200;
            while (bytes_sent < target) begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    ftype = TYPE_DATA;
                else if (r < 85)
                    ftype = 8'($urandom_range(1, int'(TYPE_KNOWN_MAX)));
                else
                    ftype = 8'($urandom_range(int'(TYPE_KNOWN_MAX) + 1, 255));
                r = $urandom_range(0, 99);
                if (r < 10)
                    len = '0;
                else if (r < 92)
                    len = 24'($urandom_range(1, 16));
                else
                    len = 24'($urandom_range(17, 300));
                send_header(ftype, 8'($urandom()), $urandom(), len);
                // now and then reload the window between header and payload
                if ($urandom_range(0, 7) == 0) begin
                    settle();
                    write_window(31'($urandom_range(0, 600)));
                end
                send_payload(int'(len));
            end
            settle();
        end
        calm = 1'b0;
    endtask

    // Largest length, exactly equal to the window; frame left open at the end
    task automatic test_long_frame();
        write_window(31'h00FF_FFFF);
        send_header(TYPE_DATA, 8'h00, 32'h8000_0000, 24'hFF_FFFF);
        send_payload(20);
        settle();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_window();
        test_frame_types();
        test_window_edges();
        test_random_traffic();
        test_long_frame();
        if (fail_cnt == 0 && deframed_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
